// ----- sv/rksm_pkg.sv -----
package rksm_pkg;

    // Sizing
    localparam int MAX_PATTERN = 255;
    localparam int POS_BITS    = 32;
    localparam int RING_DEPTH  = MAX_PATTERN + 1;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
    localparam int WCNT_W      = $clog2(RING_DEPTH + 1);
    localparam int START_W     = 32;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int OCC_W       = $clog2(FIFO_DEPTH + 1);

    // Hash arithmetic
    localparam int HASH_W = 30;
    localparam logic [HASH_W-1:0] HASH_MOD = HASH_W'(1000000009);
    localparam logic [HASH_W-1:0] HASH_ONE = HASH_W'(1);
    localparam int SV_W        = 9;    // signed char minus offset: -224..31
    localparam int CHAR_OFFSET = 96;
    localparam int BIAS_MULT   = 224;  // lifts the signed product to nonnegative

    // Product plus bias stays below 255 * modulus
    localparam int PROD_W = 38;
    localparam logic [PROD_W-1:0] PROD_BIAS = PROD_W'(64'(BIAS_MULT) * 64'(HASH_MOD));

    // Quotient estimate: q ~= (y >> QUOT_LSB) * RECIP >> RECIP_SHIFT, low by at most one
    localparam int QUOT_LSB    = 29;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << (QUOT_LSB + RECIP_SHIFT)) / 64'(HASH_MOD));
    localparam int T_W   = PROD_W - QUOT_LSB;
    localparam int Y31_W = HASH_W + 5;
    localparam int T31_W = Y31_W - QUOT_LSB;

    // Control that travels with an item through the hash pipeline
    typedef struct packed {
        logic               text;
        logic               load;
        logic               first_p;
        logic               clr_text;
        logic               check;
        logic               first_win;
        logic [RING_AW-1:0] wptr;
        logic [RING_AW-1:0] idx;
        logic [START_W-1:0] start;
        logic               ovf;
    } item_ctrl_t;

    // One result, match in bit 0
    typedef struct packed {
        logic               pattern_overflow;
        logic [START_W-1:0] match_start;
        logic               match;
    } result_t;

    localparam int RES_W = $bits(result_t);
    localparam int OUT_W = ((RES_W + 7) / 8) * 8;

    // x * 31 mod P in one pass
    function automatic logic [HASH_W-1:0] times_base(input logic [HASH_W-1:0] x);
        logic [Y31_W-1:0]         y;
        logic [T31_W-1:0]         t;
        logic [T31_W+RECIP_W-1:0] qc;
        logic [T31_W-1:0]         q;
        logic [Y31_W-1:0]         r;
        y  = {x, 5'b0} - Y31_W'(x);
        t  = y[Y31_W-1:QUOT_LSB];
        qc = (T31_W+RECIP_W)'(t) * (T31_W+RECIP_W)'(RECIP);
        q  = qc[T31_W+RECIP_W-1:RECIP_SHIFT];
        r  = y - Y31_W'(q) * Y31_W'(HASH_MOD);
        if (r >= Y31_W'(HASH_MOD)) begin
            r = r - Y31_W'(HASH_MOD);
        end
        return r[HASH_W-1:0];
    endfunction

    // (a + b) mod P for a, b below P
    function automatic logic [HASH_W-1:0] add_mod(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [HASH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, HASH_MOD}) begin
            s = s - {1'b0, HASH_MOD};
        end
        return s[HASH_W-1:0];
    endfunction

    // (a - b) mod P for a, b below P
    function automatic logic [HASH_W-1:0] sub_mod(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [HASH_W:0] s;
        if (a >= b) begin
            s = {1'b0, a} - {1'b0, b};
        end else begin
            s = {1'b0, a} + {1'b0, HASH_MOD} - {1'b0, b};
        end
        return s[HASH_W-1:0];
    endfunction

endpackage

// ----- sv/rksm_ram.sv -----
module rksm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port (old data on a collision)
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/rksm_term_pipe.sv -----
module rksm_term_pipe (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    input  logic signed [rksm_pkg::SV_W-1:0]   in_sv,
    input  logic [rksm_pkg::HASH_W-1:0]    in_op,
    input  rksm_pkg::item_ctrl_t           in_ctrl,
    output logic                           out_valid,
    output logic [rksm_pkg::HASH_W-1:0]    out_term,
    output rksm_pkg::item_ctrl_t           out_ctrl
);

    import rksm_pkg::*;

    // Stage A: operands
    logic                     va_reg;
    logic signed [SV_W-1:0]   sv_a_reg;
    logic [HASH_W-1:0]        op_a_reg;
    item_ctrl_t               ctrl_a_reg;
    // Stage B: biased product
    logic                     vb_reg;
    logic [PROD_W-1:0]        y_b_reg;
    item_ctrl_t               ctrl_b_reg;
    // Stage C: product and quotient estimate
    logic                     vc_reg;
    logic [PROD_W-1:0]        y_c_reg;
    logic [T_W-1:0]           q_c_reg;
    item_ctrl_t               ctrl_c_reg;
    // Stage D: reduced term
    logic                     vd_reg;
    logic [HASH_W-1:0]        term_d_reg;
    item_ctrl_t               ctrl_d_reg;

    logic signed [PROD_W:0]   prod;
    logic [PROD_W-1:0]        y_b_next;
    logic [T_W-1:0]           t_b;
    logic [T_W+RECIP_W-1:0]   qc_b;
    logic [T_W-1:0]           q_c_next;
    logic [PROD_W-1:0]        r_c;
    logic [HASH_W-1:0]        term_d_next;

    // Signed value times power, lifted by a multiple of P
    always_comb begin
        prod     = (PROD_W+1)'(sv_a_reg) * (PROD_W+1)'($signed({1'b0, op_a_reg}));
        y_b_next = prod[PROD_W-1:0] + PROD_BIAS;
    end

    // Estimate the quotient from the top bits
    always_comb begin
        t_b      = y_b_reg[PROD_W-1:QUOT_LSB];
        qc_b     = (T_W+RECIP_W)'(t_b) * (T_W+RECIP_W)'(RECIP);
        q_c_next = qc_b[T_W+RECIP_W-1:RECIP_SHIFT];
    end

    // Subtract the estimate, correct once
    always_comb begin
        r_c = y_c_reg - PROD_W'(q_c_reg) * PROD_W'(HASH_MOD);
        if (r_c >= PROD_W'(HASH_MOD)) begin
            r_c = r_c - PROD_W'(HASH_MOD);
        end
        term_d_next = r_c[HASH_W-1:0];
    end

    // Valid chain
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
        end
    end

    // Payload stages
    always_ff @(posedge aclk) begin
        sv_a_reg   <= in_sv;
        op_a_reg   <= in_op;
        ctrl_a_reg <= in_ctrl;
        y_b_reg    <= y_b_next;
        ctrl_b_reg <= ctrl_a_reg;
        y_c_reg    <= y_b_reg;
        q_c_reg    <= q_c_next;
        ctrl_c_reg <= ctrl_b_reg;
        term_d_reg <= term_d_next;
        ctrl_d_reg <= ctrl_c_reg;
    end

    assign out_valid = vd_reg;
    assign out_term  = term_d_reg;
    assign out_ctrl  = ctrl_d_reg;

endmodule

// ----- sv/rksm_fifo.sv -----
module rksm_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  rksm_pkg::result_t push_data,
    input  logic              pop,
    output logic              out_valid,
    output rksm_pkg::result_t out_data
);

    import rksm_pkg::*;

    result_t              mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [OCC_W-1:0]     count_reg;
    logic                 do_pop;

    assign do_pop    = pop && (count_reg != '0);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];

    // Store results; upstream credit keeps the queue from overflowing
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_reg + OCC_W'(push) - OCC_W'(do_pop);
        end
    end

endmodule

// ----- sv/rabin_karp_stream_matcher_core.sv -----
// Path: each item passes term-pipeline stages A to D, then the compare stage, then the result queue.
// Throughput: one item per cycle while input ready is high; one result per item, in order.
// Input ready drops while 8 items are accepted but not yet delivered (output queue credit).
// The prefix ring takes one write and one read per text byte in a single memory.
// Reset (aresetn low, synchronous) clears all hash, position and queue state;
// the ring is not swept, the first window takes a zero prefix in place of a ring read.
module rabin_karp_stream_matcher_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] byte_value
    input  logic [1:0]                   s_tuser,   // [0] kind, [1] first_of_pattern
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rksm_pkg::OUT_W-1:0]   m_tdata    // [0] match, [32:1] match_start,
                                                    // [33] pattern_overflow
);

    import rksm_pkg::*;

    // Front-end state
    logic [HASH_W-1:0]   tp_reg,   tp_next;
    logic [HASH_W-1:0]   lp_reg,   lp_next;
    logic [PLEN_W-1:0]   plen_reg, plen_next;
    logic [POS_BITS-1:0] pos_reg,  pos_next;
    logic [WCNT_W-1:0]   wcnt_reg, wcnt_next;
    logic [RING_AW-1:0]  ptr_reg,  ptr_next;
    logic                ovf_reg,  ovf_next;
    logic [OCC_W-1:0]    occ_reg,  occ_next;

    // Accumulator state
    logic [HASH_W-1:0]   cur_reg,  cur_next;
    logic [HASH_W-1:0]   ph_reg,   ph_next;
    logic [HASH_W-1:0]   sph_reg,  sph_next;

    // Compare stage
    logic                v5_reg;
    logic [HASH_W-1:0]   newh5_reg;
    logic [HASH_W-1:0]   sph5_reg;
    logic                check5_reg;
    logic                fw5_reg;
    logic [START_W-1:0]  start5_reg;
    logic                ovf5_reg;

    logic                s_xfer;
    logic                m_xfer;
    logic                kind;
    logic                first_p;
    logic                clr_text;
    logic [PLEN_W-1:0]   plen_eff;
    logic [HASH_W-1:0]   lp_eff;
    logic                load;
    logic [RING_AW-1:0]  next_ptr;
    logic [WCNT_W-1:0]   wcnt_inc;
    logic [RING_AW:0]    idx_sum;
    logic [POS_BITS-1:0] start_pos;
    logic signed [SV_W-1:0] sv;
    logic [HASH_W-1:0]   op;
    item_ctrl_t          ctrl_in;

    logic                t_valid;
    logic [HASH_W-1:0]   t_term;
    item_ctrl_t          t_ctrl;
    logic [HASH_W-1:0]   acc_base;
    logic [HASH_W-1:0]   acc_sum;

    logic [HASH_W-1:0]   ring_rdata;
    logic [HASH_W-1:0]   ring_val;
    logic [HASH_W-1:0]   diff;
    result_t             res;
    result_t             q_data;
    logic                q_valid;

    assign s_tready = (occ_reg < OCC_W'(FIFO_DEPTH));
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    // Decode the item and step the position, power and pattern state
    always_comb begin
        kind      = s_tuser[0];
        first_p   = !kind && s_tuser[1];
        clr_text  = !kind && (s_tuser[1] || (wcnt_reg != '0));
        plen_eff  = first_p ? '0 : plen_reg;
        lp_eff    = first_p ? HASH_ONE : lp_reg;
        load      = !kind && (plen_eff < PLEN_W'(MAX_PATTERN));
        next_ptr  = (ptr_reg == RING_AW'(RING_DEPTH - 1)) ? '0 : ptr_reg + RING_AW'(1);
        wcnt_inc  = (wcnt_reg == WCNT_W'(RING_DEPTH)) ? wcnt_reg : wcnt_reg + WCNT_W'(1);
        idx_sum   = {1'b0, next_ptr} + (RING_AW+1)'(RING_DEPTH) - (RING_AW+1)'(plen_reg);
        if (idx_sum >= (RING_AW+1)'(RING_DEPTH)) begin
            idx_sum = idx_sum - (RING_AW+1)'(RING_DEPTH);
        end
        start_pos = pos_reg + POS_BITS'(1) - POS_BITS'(plen_reg);
        sv        = $signed({s_tdata[7], s_tdata}) - SV_W'(CHAR_OFFSET);
        op        = kind ? tp_reg : lp_eff;

        tp_next   = tp_reg;
        lp_next   = lp_reg;
        plen_next = plen_reg;
        pos_next  = pos_reg;
        wcnt_next = wcnt_reg;
        ptr_next  = ptr_reg;
        ovf_next  = ovf_reg;
        if (s_xfer) begin
            if (kind) begin
                tp_next   = times_base(tp_reg);
                pos_next  = pos_reg + POS_BITS'(1);
                wcnt_next = wcnt_inc;
                ptr_next  = next_ptr;
            end else begin
                if (clr_text) begin
                    tp_next   = HASH_ONE;
                    pos_next  = '0;
                    wcnt_next = '0;
                    ptr_next  = '0;
                end
                if (load) begin
                    lp_next   = times_base(lp_eff);
                    plen_next = plen_eff + PLEN_W'(1);
                    ovf_next  = first_p ? 1'b0 : ovf_reg;
                end else begin
                    lp_next   = lp_eff;
                    plen_next = plen_eff;
                    ovf_next  = 1'b1;
                end
            end
        end

        ctrl_in.text      = kind;
        ctrl_in.load      = load;
        ctrl_in.first_p   = first_p;
        ctrl_in.clr_text  = clr_text;
        ctrl_in.check     = kind && (plen_reg != '0) && (wcnt_inc >= WCNT_W'(plen_reg));
        ctrl_in.first_win = kind && (wcnt_inc == WCNT_W'(plen_reg));
        ctrl_in.wptr      = next_ptr;
        ctrl_in.idx       = idx_sum[RING_AW-1:0];
        ctrl_in.start     = START_W'(start_pos);
        ctrl_in.ovf       = ovf_next;

        occ_next = occ_reg + OCC_W'(s_xfer) - OCC_W'(m_xfer);
    end

    // Value times power, reduced mod P
    rksm_term_pipe u_term (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_xfer),
        .in_sv     (sv),
        .in_op     (op),
        .in_ctrl   (ctrl_in),
        .out_valid (t_valid),
        .out_term  (t_term),
        .out_ctrl  (t_ctrl)
    );

    // Accumulate prefix or pattern hash, step the shifted pattern hash
    always_comb begin
        if (t_ctrl.text) begin
            acc_base = cur_reg;
        end else if (t_ctrl.first_p) begin
            acc_base = '0;
        end else begin
            acc_base = ph_reg;
        end
        acc_sum  = add_mod(acc_base, t_term);

        cur_next = cur_reg;
        ph_next  = ph_reg;
        sph_next = sph_reg;
        if (t_valid) begin
            if (t_ctrl.text) begin
                cur_next = acc_sum;
                if (t_ctrl.check) begin
                    sph_next = t_ctrl.first_win ? ph_reg : times_base(sph_reg);
                end
            end else begin
                if (t_ctrl.load) begin
                    ph_next = acc_sum;
                end
                if (t_ctrl.clr_text) begin
                    cur_next = '0;
                    sph_next = '0;
                end
            end
        end
    end

    // Prefix ring: write the new prefix, read the one at the window start
    rksm_ram #(
        .WIDTH (HASH_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (t_valid && t_ctrl.text),
        .waddr (t_ctrl.wptr),
        .wdata (acc_sum),
        .raddr (t_ctrl.idx),
        .rdata (ring_rdata)
    );

    // Compare the window hash against the shifted pattern hash
    always_comb begin
        ring_val             = fw5_reg ? '0 : ring_rdata;
        diff                 = sub_mod(newh5_reg, ring_val);
        res.match            = check5_reg && (diff == sph5_reg);
        res.match_start      = res.match ? start5_reg : '0;
        res.pattern_overflow = ovf5_reg;
    end

    // Result queue
    rksm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (v5_reg),
        .push_data (res),
        .pop       (m_tready),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    assign m_tvalid = q_valid;
    assign m_tdata  = OUT_W'(q_data);

    // Control and hash state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tp_reg   <= HASH_ONE;
            lp_reg   <= HASH_ONE;
            plen_reg <= '0;
            pos_reg  <= '0;
            wcnt_reg <= '0;
            ptr_reg  <= '0;
            ovf_reg  <= 1'b0;
            occ_reg  <= '0;
            cur_reg  <= '0;
            ph_reg   <= '0;
            sph_reg  <= '0;
            v5_reg   <= 1'b0;
        end else begin
            tp_reg   <= tp_next;
            lp_reg   <= lp_next;
            plen_reg <= plen_next;
            pos_reg  <= pos_next;
            wcnt_reg <= wcnt_next;
            ptr_reg  <= ptr_next;
            ovf_reg  <= ovf_next;
            occ_reg  <= occ_next;
            cur_reg  <= cur_next;
            ph_reg   <= ph_next;
            sph_reg  <= sph_next;
            v5_reg   <= t_valid;
        end
    end

    // Compare-stage payload
    always_ff @(posedge aclk) begin
        newh5_reg  <= acc_sum;
        sph5_reg   <= sph_next;
        check5_reg <= t_ctrl.text && t_ctrl.check;
        fw5_reg    <= t_ctrl.first_win;
        start5_reg <= t_ctrl.start;
        ovf5_reg   <= t_ctrl.ovf;
    end

endmodule

// ----- tb/sv/rksm_tb_pkg.sv -----
package rksm_tb_pkg;

    // What one input byte carries, as coded in the kind bit of s_tuser
    typedef enum logic {
        BYTE_PATTERN = 1'b0,
        BYTE_TEXT    = 1'b1
    } byte_kind_t;

endpackage

// ----- tb/sv/rksm_match_checker.sv -----
module rksm_match_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] byte_value
    input  logic [1:0]                 s_tuser,   // [0] kind, [1] first_of_pattern
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [rksm_pkg::OUT_W-1:0] m_tdata,   // [0] match, [32:1] match_start,
                                                  // [33] pattern_overflow
    output int                         failures,
    output int                         pending
);

    import rksm_pkg::*;
    import rksm_tb_pkg::*;

    localparam longint unsigned PRIME     = 64'd1000000009;
    localparam logic [HASH_W-1:0] POLY_BASE = HASH_W'(31);
    localparam int LETTER_BIAS = 96;

    // Predicted hash state
    logic [HASH_W-1:0]  prefix_ring [RING_DEPTH];
    logic [HASH_W-1:0]  text_prefix;
    logic [HASH_W-1:0]  text_pow;
    logic [HASH_W-1:0]  pat_pow;
    logic [HASH_W-1:0]  pat_hash;
    logic [HASH_W-1:0]  window_hash;
    logic [START_W-1:0] text_pos;
    logic               pat_ovf;
    int                 pat_len;
    int                 ring_wr;
    int                 window_cnt;

    result_t match_q [$];

    function automatic logic [HASH_W-1:0] mul_mod_p(input logic [HASH_W-1:0] a,
                                                    input logic [HASH_W-1:0] b);
        return HASH_W'((64'(a) * 64'(b)) % PRIME);
    endfunction

    function automatic logic [HASH_W-1:0] add_mod_p(input logic [HASH_W-1:0] a,
                                                    input logic [HASH_W-1:0] b);
        return HASH_W'((64'(a) + 64'(b)) % PRIME);
    endfunction

    // Signed char minus the letter bias, folded into the field
    function automatic logic [HASH_W-1:0] char_weight(input logic [7:0] raw);
        int v;
        v = int'($signed(raw)) - LETTER_BIAS;
        if (v < 0) begin
            v += int'(PRIME);
        end
        return HASH_W'(v);
    endfunction

    task automatic clear_text();
        text_prefix    = '0;
        text_pow       = HASH_W'(1);
        text_pos       = '0;
        ring_wr        = 0;
        prefix_ring[0] = '0;
        window_cnt     = 0;
        window_hash    = '0;
    endtask

    task automatic reset_hash_state();
        foreach (prefix_ring[i]) begin
            prefix_ring[i] = '0;
        end
        clear_text();
        pat_pow  = HASH_W'(1);
        pat_hash = '0;
        pat_len  = 0;
        pat_ovf  = 1'b0;
    endtask

    // Advance the hash state by one byte and work out its result
    task automatic hash_step(input byte_kind_t kind, input logic [7:0] raw,
                             input logic first, output result_t res);
        logic [HASH_W-1:0] w;
        logic [HASH_W-1:0] new_prefix;
        logic [HASH_W-1:0] diff;
        int                slot;
        int                rd_slot;
        w   = char_weight(raw);
        res = '0;
        if (kind == BYTE_PATTERN) begin
            if (first) begin
                pat_hash = '0;
                pat_pow  = HASH_W'(1);
                pat_len  = 0;
                pat_ovf  = 1'b0;
                clear_text();
            end else if (window_cnt > 0) begin
                clear_text();
            end
            if (pat_len < MAX_PATTERN) begin
                pat_hash = add_mod_p(pat_hash, mul_mod_p(w, pat_pow));
                pat_pow  = mul_mod_p(pat_pow, POLY_BASE);
                pat_len++;
            end else begin
                pat_ovf = 1'b1;
            end
        end else begin
            new_prefix        = add_mod_p(text_prefix, mul_mod_p(w, text_pow));
            slot              = (ring_wr + 1) % RING_DEPTH;
            prefix_ring[slot] = new_prefix;
            if (window_cnt < RING_DEPTH) begin
                window_cnt++;
            end
            // Compare the window hash against the pattern hash shifted to the window start
            if (pat_len > 0 && window_cnt >= pat_len) begin
                rd_slot = (slot + RING_DEPTH - pat_len) % RING_DEPTH;
                if (window_cnt == pat_len) begin
                    window_hash = pat_hash;
                end else begin
                    window_hash = mul_mod_p(window_hash, POLY_BASE);
                end
                diff = HASH_W'((64'(new_prefix) + PRIME - 64'(prefix_ring[rd_slot])) % PRIME);
                if (diff == window_hash) begin
                    res.match       = 1'b1;
                    res.match_start = text_pos + START_W'(1) - START_W'(pat_len);
                end
            end
            text_pos    = text_pos + START_W'(1);
            text_pow    = mul_mod_p(text_pow, POLY_BASE);
            text_prefix = new_prefix;
            ring_wr     = slot;
        end
        res.pattern_overflow = pat_ovf;
    endtask

    // Check each result transfer against the oldest prediction, then predict new input
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            reset_hash_state();
            match_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[RES_W-1:0]);
                if (match_q.size() == 0) begin
                    $error("result transfer with no item outstanding: m_tdata %h", m_tdata);
                    failures++;
                end else begin
                    want = match_q.pop_front();
                    if (got.match !== want.match) begin
                        $error("match: expected %0d, got %0d", want.match, got.match);
                        failures++;
                    end
                    if (got.match_start !== want.match_start) begin
                        $error("match_start: expected %0d, got %0d",
                               want.match_start, got.match_start);
                        failures++;
                    end
                    if (got.pattern_overflow !== want.pattern_overflow) begin
                        $error("pattern_overflow: expected %0d, got %0d",
                               want.pattern_overflow, got.pattern_overflow);
                        failures++;
                    end
                    if (m_tdata[OUT_W-1:RES_W] !== '0) begin
                        $error("tdata padding: expected 0, got %h", m_tdata[OUT_W-1:RES_W]);
                        failures++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                hash_step(byte_kind_t'(s_tuser[0]), s_tdata, s_tuser[1], want);
                match_q = {match_q, want};
            end
        end
        pending = match_q.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    import rksm_pkg::*;
    import rksm_tb_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 90;
    localparam int HOLD_ITEMS   = 24;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 40;
    localparam int CALM_ITEMS   = 20;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [7:0]       s_tdata;
    logic [1:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    int         failures;
    int         pending;
    int         cycle_count = 0;
    int         items_sent  = 0;
    bit         tx_idle_on;
    bit         rx_idle_on;
    bit         hold_req;
    logic [7:0] pattern_q [$];

    rabin_karp_stream_matcher_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rksm_match_checker match_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .failures (failures),
        .pending  (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin : result_sink
        int stall_len;
        bit hold_done;
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_done = 1'b1;
                m_tready  = 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                m_tready  = 1'b0;
                stall_len = $urandom_range(1, 9);
                repeat (stall_len - 1) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Mostly two letters so that windows match often; now and then any byte
    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 3) == 0) begin
            return 8'($urandom_range(0, 255));
        end
        return 8'h61 + 8'($urandom_range(0, 1));
    endfunction

    // Offer one byte, optionally after an idle burst, and hold it until the transfer
    task automatic send_item(input byte_kind_t kind, input logic [7:0] value,
                             input logic first);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        s_tuser  = {first, logic'(kind)};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        items_sent++;
    endtask

    // Hold the sender until every prediction has been matched by a result
    task automatic drain();
        wait (pending == 0);
        @(negedge aclk);
    endtask

    // Text with copies of the current pattern dropped in; first flag is noise here
    task automatic send_text_run(input int len);
        int k;
        k = 0;
        while (k < len) begin
            if (pattern_q.size() > 0 && $urandom_range(0, 2) == 0) begin
                foreach (pattern_q[j]) begin
                    send_item(BYTE_TEXT, pattern_q[j], 1'($urandom_range(0, 1)));
                end
                k += pattern_q.size();
            end else begin
                send_item(BYTE_TEXT, pick_char(), 1'($urandom_range(0, 1)));
                k++;
            end
        end
    endtask

    // New pattern (or an extension of the old one after its text), then text
    task automatic pattern_then_text(input int m, input int text_len);
        logic [7:0] c;
        if (pattern_q.size() > 0 && pattern_q.size() < 200 && $urandom_range(0, 5) == 0) begin
            repeat (m) begin
                c = pick_char();
                pattern_q = {pattern_q, c};
                send_item(BYTE_PATTERN, c, 1'b0);
            end
        end else begin
            pattern_q.delete();
            for (int k = 0; k < m; k++) begin
                c = pick_char();
                pattern_q = {pattern_q, c};
                send_item(BYTE_PATTERN, c, k == 0);
            end
        end
        send_text_run(text_len);
    endtask

    // Overlong pattern: the tail is dropped and every result from the first dropped byte on reports the overflow
    task automatic long_pattern_run();
        for (int k = 0; k < MAX_PATTERN + 3; k++) begin
            send_item(BYTE_PATTERN, pick_char(), k == 0);
        end
        repeat (3) send_item(BYTE_TEXT, pick_char(), 1'b0);
        pattern_q.delete();
    endtask

    task automatic noise_run();
        repeat ($urandom_range(1, 6)) begin
            send_item(byte_kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        end
        pattern_q.delete();
    endtask

    task automatic directed_run();
        // Text before any pattern, first flag set on text
        send_item(BYTE_TEXT, 8'h61, 1'b1);
        send_item(BYTE_TEXT, 8'h00, 1'b0);
        // Pattern "ab", short text, then two matches
        send_item(BYTE_PATTERN, 8'h61, 1'b1);
        send_item(BYTE_PATTERN, 8'h62, 1'b0);
        send_item(BYTE_TEXT, 8'h61, 1'b0);
        send_item(BYTE_TEXT, 8'h62, 1'b0);
        send_item(BYTE_TEXT, 8'h61, 1'b1);
        send_item(BYTE_TEXT, 8'h62, 1'b0);
        // Pattern byte after text extends to "abc" and restarts the text
        send_item(BYTE_PATTERN, 8'h63, 1'b0);
        send_item(BYTE_TEXT, 8'h61, 1'b0);
        send_item(BYTE_TEXT, 8'h62, 1'b0);
        send_item(BYTE_TEXT, 8'h63, 1'b0);
        // Byte extremes on both sides
        send_item(BYTE_PATTERN, 8'hFF, 1'b1);
        send_item(BYTE_PATTERN, 8'h80, 1'b0);
        send_item(BYTE_PATTERN, 8'h00, 1'b0);
        send_item(BYTE_PATTERN, 8'h7F, 1'b0);
        send_item(BYTE_TEXT, 8'hFF, 1'b0);
        send_item(BYTE_TEXT, 8'h80, 1'b0);
        send_item(BYTE_TEXT, 8'h00, 1'b0);
        send_item(BYTE_TEXT, 8'h7F, 1'b0);
        send_item(BYTE_TEXT, 8'hFF, 1'b0);
        send_item(BYTE_TEXT, 8'h80, 1'b0);
        send_item(BYTE_TEXT, 8'h00, 1'b0);
        send_item(BYTE_TEXT, 8'h7F, 1'b0);
        // Single byte whose weight is zero
        send_item(BYTE_PATTERN, 8'h60, 1'b1);
        send_item(BYTE_TEXT, 8'h60, 1'b0);
        send_item(BYTE_TEXT, 8'h41, 1'b0);
    endtask

    initial begin : stimulus
        int random_end;
        int m;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        hold_req   = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        directed_run();
        drain();

        // Receiver holds off while the sender keeps offering: fill the block
        hold_req = 1'b1;
        repeat (HOLD_ITEMS) send_item(BYTE_TEXT, pick_char(), 1'b0);
        hold_req = 1'b0;
        drain();

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        long_pattern_run();
        // Short pattern across a text long enough to wrap the prefix ring
        pattern_then_text(3, RING_DEPTH + 6);

        random_end = items_sent + RANDOM_ITEMS;
        while (items_sent < random_end) begin
            // Change the idle mix per run; none toward the end
            if (items_sent < random_end - CALM_ITEMS) begin
                tx_idle_on = $urandom_range(0, 2) != 0;
                rx_idle_on = $urandom_range(0, 2) != 0;
            end else begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if ($urandom_range(0, 7) == 0) begin
                noise_run();
            end else begin
                if ($urandom_range(0, 7) == 0) begin
                    m = $urandom_range(6, 16);
                end else begin
                    m = $urandom_range(1, 5);
                end
                pattern_then_text(m, $urandom_range(4, 30));
            end
            if ($urandom_range(0, 9) == 0) begin
                drain();
            end
        end

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
